[src/tbpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_pkg: shared types and constants of the two-best peak finder
// Widths of the sample and result fields and the beat structs that travel
// between the input stage, the peak tracker and the top level.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int POS_W       = $clog2(MAX_SAMPLES);
  localparam int IDX_W       = 12;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 2;
  localparam int LIST_DEPTH  = 2;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SAMPLES - 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } item_t;

  typedef struct packed {
    logic        [COUNT_W-1:0] peak_count;
    logic        [IDX_W-1:0]   first_index;
    logic signed [DATA_W-1:0]  first_value;
    logic        [IDX_W-1:0]   second_index;
    logic signed [DATA_W-1:0]  second_value;
  } result_t;

endpackage

[src/tbpf_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_ifs: channel interfaces of the two-best peak finder
// The sample channel and the result channel, each with valid, ready and
// its payload fields.
// ----------------------------------------------------------------------------
interface tbpf_in_if import tbpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic                     last_sample;

  modport source(output valid, output sample, output last_sample, input ready);
  modport sink(input valid, input sample, input last_sample, output ready);
endinterface

interface tbpf_out_if import tbpf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [COUNT_W-1:0] peak_count;
  logic        [IDX_W-1:0]   first_index;
  logic signed [DATA_W-1:0]  first_value;
  logic        [IDX_W-1:0]   second_index;
  logic signed [DATA_W-1:0]  second_value;

  modport source(output valid, output peak_count, output first_index,
                 output first_value, output second_index, output second_value,
                 input ready);
  modport sink(input valid, input peak_count, input first_index,
               input first_value, input second_index, input second_value,
               output ready);
endinterface

[src/tbpf_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_in_stage: input register
// Captures one sample beat and holds it until the tracker consumes it.
// ----------------------------------------------------------------------------
module tbpf_in_stage import tbpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tbpf_in_if.sink    in_if,
  input  logic       advance,
  output item_t      item,
  output logic       item_valid
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r.sample      <= in_if.sample;
      item_r.last_sample <= in_if.last_sample;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

[src/tbpf_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_track: peak tracker and two-entry list
// Updates the running maximum, the levels and the open peak for one sample,
// inserts a closed peak into the sorted list and forms the frame result.
// ----------------------------------------------------------------------------
module tbpf_track import tbpf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  output result_t res
);

  localparam logic signed [DATA_W-1:0] DATA_ZERO = '0;

  logic        [POS_W-1:0]   pos_r,   pos_nxt;
  logic signed [DATA_W-1:0]  rmax_r,  rmax_nxt;
  logic signed [DATA_W-1:0]  left_r,  left_nxt;
  logic signed [DATA_W-1:0]  thr_r,   thr_nxt;
  logic        [POS_W-1:0]   cand_r,  cand_nxt;
  logic                      inpk_r,  inpk_nxt;
  logic        [POS_W-1:0]   p0_r,    p0_nxt;
  logic        [POS_W-1:0]   p1_r,    p1_nxt;
  logic signed [DATA_W-1:0]  v0_r,    v0_nxt;
  logic signed [DATA_W-1:0]  v1_r,    v1_nxt;
  logic        [COUNT_W-1:0] fill_r,  fill_nxt;

  logic signed [DATA_W-1:0]  s;
  logic signed [DATA_W-1:0]  half_s;
  logic signed [DATA_W-1:0]  clamp_s;
  logic        [COUNT_W-1:0] slot;
  logic                      full;

  assign s       = item.sample;
  assign half_s  = s >>> 1;
  assign clamp_s = (s > DATA_ZERO) ? s : DATA_ZERO;
  assign full    = fill_r >= COUNT_W'(LIST_DEPTH);

  always_comb begin
    pos_nxt  = pos_r;
    rmax_nxt = rmax_r;
    left_nxt = left_r;
    thr_nxt  = thr_r;
    cand_nxt = cand_r;
    inpk_nxt = inpk_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    fill_nxt = fill_r;
    slot     = full ? COUNT_W'(1) : fill_r;

    if (pos_r == '0) begin
      rmax_nxt = s;
      left_nxt = s;
      thr_nxt  = DATA_ZERO;
      cand_nxt = '0;
      inpk_nxt = 1'b0;
      fill_nxt = '0;
      p0_nxt   = '0;
      p1_nxt   = '0;
      v0_nxt   = DATA_ZERO;
      v1_nxt   = DATA_ZERO;
    end else if (s > rmax_r) begin
      rmax_nxt = s;
      if (half_s > left_r) begin
        cand_nxt = pos_r;
        inpk_nxt = 1'b1;
        thr_nxt  = half_s;
      end
    end else if (inpk_r && (s < thr_r)) begin
      if (!(full && (v1_r > rmax_r))) begin
        if ((slot == COUNT_W'(1)) && (v0_r < rmax_r)) begin
          p1_nxt = p0_r;
          v1_nxt = v0_r;
          p0_nxt = cand_r;
          v0_nxt = rmax_r;
        end else if (slot == '0) begin
          p0_nxt = cand_r;
          v0_nxt = rmax_r;
        end else begin
          p1_nxt = cand_r;
          v1_nxt = rmax_r;
        end
        fill_nxt = slot + COUNT_W'(1);
      end
      inpk_nxt = 1'b0;
      rmax_nxt = clamp_s;
      left_nxt = clamp_s;
    end else if (!inpk_r && (s < left_r)) begin
      rmax_nxt = clamp_s;
      left_nxt = clamp_s;
    end

    if (item.last_sample) begin
      pos_nxt  = '0;
      inpk_nxt = 1'b0;
    end else if (pos_r < POS_LAST) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      rmax_r <= '0;
      left_r <= '0;
      thr_r  <= '0;
      cand_r <= '0;
      inpk_r <= 1'b0;
      p0_r   <= '0;
      p1_r   <= '0;
      v0_r   <= '0;
      v1_r   <= '0;
      fill_r <= '0;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      rmax_r <= rmax_nxt;
      left_r <= left_nxt;
      thr_r  <= thr_nxt;
      cand_r <= cand_nxt;
      inpk_r <= inpk_nxt;
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      v0_r   <= v0_nxt;
      v1_r   <= v1_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    res.peak_count   = fill_nxt;
    res.first_index  = (fill_nxt >= COUNT_W'(1)) ? IDX_W'(p0_nxt) : '0;
    res.first_value  = (fill_nxt >= COUNT_W'(1)) ? v0_nxt : DATA_ZERO;
    res.second_index = (fill_nxt >= COUNT_W'(2)) ? IDX_W'(p1_nxt) : '0;
    res.second_value = (fill_nxt >= COUNT_W'(2)) ? v1_nxt : DATA_ZERO;
  end

endmodule

[src/two_best_peak_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_best_peak_finder: top level
// Path: the last sample beat of a frame, once accepted, passes the input
// register, then the result register, which holds the result beat until taken.
// Throughput: one sample beat per cycle; only a frame-end beat, and the input
// behind it, waits while an earlier result is still held in the result register.
// Reset: clears the frame position, the levels, the open peak and the list.
// ----------------------------------------------------------------------------
module two_best_peak_finder import tbpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tbpf_in_if.sink   in_if,
  tbpf_out_if.source out_if
);

  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    emit;

  assign advance = item_valid &&
                   (!item.last_sample || !out_valid_r || out_if.ready);
  assign emit    = advance && item.last_sample;

  tbpf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  tbpf_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.peak_count   = out_r.peak_count;
  assign out_if.first_index  = out_r.first_index;
  assign out_if.first_value  = out_r.first_value;
  assign out_if.second_index = out_r.second_index;
  assign out_if.second_value = out_r.second_value;

  // The sample side stalls only behind a held result.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_if.valid && !out_if.ready))
    else $error("input stalled without a held result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.peak_count <= COUNT_W'(LIST_DEPTH)))
    else $error("peak count beyond list depth");

  // The list stays sorted by descending value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.peak_count == COUNT_W'(2))) |->
      (out_if.first_value >= out_if.second_value))
    else $error("peak list out of order");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.peak_count < COUNT_W'(2))) |->
      ((out_if.second_index == '0) && (out_if.second_value == '0)))
    else $error("unfilled second entry not zero");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the two-best peak finder
// Sends frames of Q16.16 samples over the sample channel and checks every
// frame report against a cycle-free model of the peak tracker kept in the
// bench. Directed frames cover the edge values, ties, blocked inserts,
// negative halves and peaks left open. Random frames follow, mostly pulse
// trains with some noise and broken frames. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_top import tbpf_pkg::*; ();

  typedef struct packed {
    logic  drain;
    item_t beat;
  } queued_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  tbpf_in_if  in_ch();
  tbpf_out_if out_ch();

  two_best_peak_finder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  queued_beat_t pending[$];
  result_t      frame_reports[$];
  int           shape[$];
  int           mismatches = 0;
  int           send_gap;
  int           recv_stall;
  bit           send_quiet = 1'b0;
  bit           recv_quiet = 1'b0;

  // Tracker state as seen by the bench.
  logic        [POS_W-1:0]  trk_pos = '0;
  logic signed [DATA_W-1:0] trk_max = '0;
  logic signed [DATA_W-1:0] trk_left = '0;
  logic signed [DATA_W-1:0] trk_right = '0;
  logic        [POS_W-1:0]  trk_cand = '0;
  logic                     trk_open = 1'b0;
  logic        [POS_W-1:0]  best_pos [LIST_DEPTH];
  logic signed [DATA_W-1:0] best_val [LIST_DEPTH];
  logic        [COUNT_W-1:0] best_fill = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic track_sample(input logic signed [DATA_W-1:0] s, input logic is_last);
    logic signed [DATA_W-1:0] half;
    logic signed [DATA_W-1:0] floored;
    result_t                  rep;
    logic                     k;
    half = s >>> 1;
    floored = (s > 0) ? s : 32'sd0;
    if (trk_pos == '0) begin
      trk_max = s;
      trk_left = s;
      trk_right = '0;
      trk_cand = '0;
      trk_open = 1'b0;
      best_fill = '0;
      best_pos[0] = '0;
      best_pos[1] = '0;
      best_val[0] = '0;
      best_val[1] = '0;
    end else if (s > trk_max) begin
      trk_max = s;
      if (half > trk_left) begin
        trk_cand = trk_pos;
        trk_open = 1'b1;
        trk_right = half;
      end
    end else if (trk_open && s < trk_right) begin
      if (!(best_fill >= 2 && best_val[1] > trk_max)) begin
        if (best_fill >= 2) best_fill = 2'd1;
        k = best_fill[0];
        if (best_fill == 1 && best_val[0] < trk_max) begin
          best_pos[1] = best_pos[0];
          best_val[1] = best_val[0];
          k = 1'b0;
        end
        best_pos[k] = trk_cand;
        best_val[k] = trk_max;
        best_fill = best_fill + 2'd1;
      end
      trk_open = 1'b0;
      trk_max = floored;
      trk_left = floored;
    end else if (!trk_open && s < trk_left) begin
      trk_max = floored;
      trk_left = floored;
    end

    if (is_last) begin
      rep.peak_count   = best_fill;
      rep.first_index  = (best_fill >= 1) ? IDX_W'(best_pos[0]) : '0;
      rep.first_value  = (best_fill >= 1) ? best_val[0] : '0;
      rep.second_index = (best_fill >= 2) ? IDX_W'(best_pos[1]) : '0;
      rep.second_value = (best_fill >= 2) ? best_val[1] : '0;
      frame_reports.insert(frame_reports.size(), rep);
      trk_pos = '0;
      trk_open = 1'b0;
    end else if (trk_pos != POS_LAST) begin
      trk_pos = trk_pos + POS_W'(1);
    end
  endtask

  always @(posedge clk) begin : sender
    queued_beat_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
      in_ch.last_sample <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) track_sample(in_ch.sample, in_ch.last_sample);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          in_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && frame_reports.size() != 0)) begin
          nxt = pending.pop_front();
          in_ch.sample <= nxt.beat.sample;
          in_ch.last_sample <= nxt.beat.last_sample;
          in_ch.valid <= 1'b1;
          send_gap <= draw_wait(send_quiet);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : receiver
    result_t want;
    int      w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (frame_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual count %0d idx %0d/%0d",
                 $time, out_ch.peak_count, out_ch.first_index, out_ch.second_index);
        mismatches++;
      end else begin
        want = frame_reports.pop_front();
        check_field("peak_count", want.peak_count, out_ch.peak_count);
        check_field("first_index", want.first_index, out_ch.first_index);
        check_field("first_value", want.first_value, out_ch.first_value);
        check_field("second_index", want.second_index, out_ch.second_index);
        check_field("second_value", want.second_value, out_ch.second_value);
      end
      w = draw_wait(recv_quiet);
      recv_stall <= w;
      out_ch.ready <= (w == 0);
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      out_ch.ready <= (recv_stall == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic emit_frame(input bit drain);
    queued_beat_t qb;
    for (int i = 0; i < shape.size(); i++) begin
      qb.drain = drain && (i == 0);
      qb.beat.sample = shape[i];
      qb.beat.last_sample = (i == shape.size() - 1);
      pending.insert(pending.size(), qb);
    end
    shape.delete();
  endtask

  task automatic build_pulse_frame(input int len, input bit leave_open);
    longint base;
    longint top;
    int     rise;
    base = longint'($urandom_range(0, 4000)) - 2000;
    if ($urandom_range(0, 9) == 0) base = -64'sd2147483648 + $urandom_range(0, 100);
    while (shape.size() < len) begin
      case ($urandom_range(0, 4))
        0: shape.insert(shape.size(), int'(base + longint'($urandom_range(0, 16)) - 8));
        1: begin
          base = longint'($urandom_range(0, 4000)) - 2000;
          shape.insert(shape.size(), int'(base));
        end
        default: begin
          top = base + (longint'($urandom_range(1, 1 << 20)) << $urandom_range(0, 11));
          if (top > 64'sd2147483647) top = 64'sd2147483647;
          rise = $urandom_range(1, 3);
          for (int r = 1; r <= rise; r++) begin
            shape.insert(shape.size(), int'(base + (top - base) * r / rise));
          end
          if ($urandom_range(0, 3) == 0) shape.insert(shape.size(), int'(top - 1));
          if ($urandom_range(0, 4) == 0) shape.insert(shape.size(), int'(top / 2 + 1));
          shape.insert(shape.size(), int'(base + longint'($urandom_range(0, 16)) - 8));
        end
      endcase
    end
    while (shape.size() > len) shape.delete(shape.size() - 1);
    if (leave_open) shape[shape.size() - 1] = 32'sh7fffffff;
  endtask

  initial begin : stimulus
    int total;
    int frames;
    int len;
    int kind;

    // Single-sample frames at both extremes.
    shape = '{32'sh7fffffff};
    emit_frame(1'b0);
    shape = '{32'sh80000000};
    emit_frame(1'b0);
    // Extreme swing: lowest seed, highest peak, closed by lowest value.
    shape = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0};
    emit_frame(1'b0);
    // Ties go after, a lower peak is blocked, a higher one displaces the
    // last entry, an equal one replaces it, and the final peak stays open.
    shape = '{0, 100, 10, 100, 0, 40, 0, 200, 0, 100, 0, 300};
    emit_frame(1'b1);
    // Negative half rounds down; a rise whose half stays below the left
    // level opens nothing; a drop below the left level resets the levels.
    shape = '{-3, -1, -2, -5, 5};
    emit_frame(1'b0);
    shape = '{100, 150, 20};
    emit_frame(1'b0);

    total = pending.size();
    frames = 0;
    while (total < 1850) begin
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250) : $urandom_range(2, 40);
      if (kind < 7) begin
        build_pulse_frame(len, 1'b0);
      end else if (kind < 9) begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) shape.insert(shape.size(), int'($urandom()));
      end else if ($urandom_range(0, 1) == 0) begin
        build_pulse_frame(len, 1'b1);
      end else begin
        shape.insert(shape.size(), int'($urandom()));
      end
      total += shape.size();
      emit_frame(frames % 15 == 0);
      frames++;
    end

    do @(negedge clk);
    while (pending.size() != 0 || in_ch.valid || frame_reports.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("two_best_peak_finder regression: pass");
    end else begin
      $display("two_best_peak_finder regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("two_best_peak_finder regression: fail");
    $finish;
  end

endmodule

[two_best_peak_finder.f]
src/tbpf_pkg.sv
src/tbpf_ifs.sv
src/tbpf_in_stage.sv
src/tbpf_track.sv
src/two_best_peak_finder.sv
sim/tb_top.sv
